@@ rtl/b64ce_pkg.sv @@
// ----------------------------------------------------------------------------
// b64ce_pkg
// Shared types, character codes and the Base64 symbol table of the
// caret-escaped Base64 encoder.
// ----------------------------------------------------------------------------
package b64ce_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CharW    = 7;
    localparam int unsigned SymW     = 6;
    localparam int unsigned CarryW   = 4;
    localparam int unsigned MaxChars = 6;
    localparam int unsigned CntW     = $clog2(MaxChars + 1);

    localparam logic [CharW-1:0] PadChar   = 7'h3D;  // '='
    localparam logic [CharW-1:0] EscChar   = 7'h5E;  // '^'
    localparam logic [CharW-1:0] PlusChar  = 7'h2B;  // '+'
    localparam logic [CharW-1:0] SlashChar = 7'h2F;  // '/'

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef logic [MaxChars-1:0][CharW-1:0] t_chars;

    // everything one byte produces, plus the group state it leaves behind
    typedef struct packed {
        t_chars            chars;
        logic [CntW-1:0]   count;
        t_phase            phase;
        logic [CarryW-1:0] carry;
    } t_burst;

    function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] v);
        logic [CharW-1:0] w;
        logic [CharW-1:0] c;
        w = {1'b0, v};
        case (v) inside
            [6'd0:6'd25]:  c = w + 7'h41;
            [6'd26:6'd51]: c = w + 7'h47;
            [6'd52:6'd61]: c = w - 7'h04;
            6'd62:         c = PlusChar;
            default:       c = SlashChar;
        endcase
        return c;
    endfunction

    function automatic logic sym_upper(input logic [SymW-1:0] v);
        return v < 6'd26;
    endfunction

endpackage

@@ rtl/b64ce_group.sv @@
// ----------------------------------------------------------------------------
// b64ce_group
// Splits one byte into Base64 symbols for the current group position and
// expands them into output characters: escapes, letters and pads.
// ----------------------------------------------------------------------------
module b64ce_group (
    input  logic [b64ce_pkg::ByteW-1:0]  i_byte,
    input  logic                         i_last,
    input  b64ce_pkg::t_phase            i_phase,
    input  logic [b64ce_pkg::CarryW-1:0] i_carry,
    output b64ce_pkg::t_burst            o_burst
);

    logic [b64ce_pkg::SymW-1:0]   sym0;
    logic [b64ce_pkg::SymW-1:0]   sym1;
    logic                         sym1_vld;
    logic [1:0]                   pads;
    b64ce_pkg::t_phase            nxt_phase;
    logic [b64ce_pkg::CarryW-1:0] nxt_carry;
    b64ce_pkg::t_chars            chars;
    logic [b64ce_pkg::CntW-1:0]   cnt;

    assign o_burst = {chars, cnt, nxt_phase, nxt_carry};

    always_comb begin
        sym1      = '0;
        sym1_vld  = 1'b0;
        pads      = 2'd0;
        nxt_phase = b64ce_pkg::PH_FIRST;
        nxt_carry = '0;
        case (i_phase)
            b64ce_pkg::PH_SECOND: begin
                sym0 = {i_carry[1:0], i_byte[7:4]};
                nxt_phase = b64ce_pkg::PH_THIRD;
                nxt_carry = i_byte[3:0];
                if (i_last) begin
                    sym1     = {i_byte[3:0], 2'b00};
                    sym1_vld = 1'b1;
                    pads     = 2'd1;
                end
            end
            b64ce_pkg::PH_THIRD: begin
                sym0     = {i_carry, i_byte[7:6]};
                sym1     = i_byte[5:0];
                sym1_vld = 1'b1;
            end
            default: begin
                // unused phase code behaves as start of group
                sym0 = i_byte[7:2];
                nxt_phase = b64ce_pkg::PH_SECOND;
                nxt_carry = {2'b00, i_byte[1:0]};
                if (i_last) begin
                    sym1     = {i_byte[1:0], 4'b0000};
                    sym1_vld = 1'b1;
                    pads     = 2'd2;
                end
            end
        endcase
        if (i_last) begin
            nxt_phase = b64ce_pkg::PH_FIRST;
            nxt_carry = '0;
        end
    end

    // pack characters low slot first
    always_comb begin
        logic [b64ce_pkg::CntW-1:0] pos;
        pos   = '0;
        chars = '0;
        if (b64ce_pkg::sym_upper(sym0)) begin
            chars[pos] = b64ce_pkg::EscChar;
            pos = pos + 1'b1;
        end
        chars[pos] = b64ce_pkg::sym_char(sym0);
        pos = pos + 1'b1;
        if (sym1_vld) begin
            if (b64ce_pkg::sym_upper(sym1)) begin
                chars[pos] = b64ce_pkg::EscChar;
                pos = pos + 1'b1;
            end
            chars[pos] = b64ce_pkg::sym_char(sym1);
            pos = pos + 1'b1;
        end
        if (pads != 2'd0) begin
            chars[pos] = b64ce_pkg::PadChar;
            pos = pos + 1'b1;
        end
        if (pads == 2'd2) begin
            chars[pos] = b64ce_pkg::PadChar;
            pos = pos + 1'b1;
        end
        cnt = pos;
    end

endmodule

@@ rtl/base64_encoder_caret_escape.sv @@
// ----------------------------------------------------------------------------
// base64_encoder_caret_escape
// Byte-stream Base64 encoder with '^' before every uppercase letter.
// ----------------------------------------------------------------------------
// Each accepted byte is encoded into a burst of 1 to 6 characters held in a
// shift buffer, which sends one character per output beat. A byte's
// characters (1-6, about 1.9 on average for random data) all leave before
// the next byte is accepted, which happens in the same cycle the buffer's
// final character leaves, so with the output always ready the rate is set
// by the single output port at one character a cycle.
// run_end flags the last character of each byte, message_end the last
// character of a message. Empty messages are not supported.
module base64_encoder_caret_escape (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [b64ce_pkg::ByteW-1:0]   i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [b64ce_pkg::CharW-1:0]   o_out_char,
    output logic                          o_run_end,
    output logic                          o_message_end
);

    b64ce_pkg::t_phase            r_phase, n_phase;
    logic [b64ce_pkg::CarryW-1:0] r_carry, n_carry;
    b64ce_pkg::t_chars            r_chars, n_chars;
    logic [b64ce_pkg::CntW-1:0]   r_cnt, n_cnt;
    logic                         r_last, n_last;

    b64ce_pkg::t_burst burst;
    logic              in_fire;
    logic              out_fire;

    b64ce_group u_group (
        .i_byte  (i_data_byte),
        .i_last  (i_last_byte),
        .i_phase (r_phase),
        .i_carry (r_carry),
        .o_burst (burst)
    );

    assign o_out_valid   = (r_cnt != '0);
    assign o_in_ready    = (r_cnt == '0) || ((r_cnt == 1) && i_out_ready);
    assign in_fire       = i_in_valid && o_in_ready;
    assign out_fire      = o_out_valid && i_out_ready;
    assign o_out_char    = r_chars[0];
    assign o_run_end     = (r_cnt == 1);
    assign o_message_end = (r_cnt == 1) && r_last;

    always_comb begin
        n_phase = r_phase;
        n_carry = r_carry;
        n_chars = r_chars;
        n_cnt   = r_cnt;
        n_last  = r_last;
        if (in_fire) begin
            n_phase = burst.phase;
            n_carry = burst.carry;
            n_chars = burst.chars;
            n_cnt   = burst.count;
            n_last  = i_last_byte;
        end else if (out_fire) begin
            n_chars = r_chars >> b64ce_pkg::CharW;
            n_cnt   = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64ce_pkg::PH_FIRST;
            r_carry <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_carry <= n_carry;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= b64ce_pkg::MaxChars)
        else $error("character count out of range");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_cnt != '0))
        else $error("accepted byte produced no characters");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_last_byte) |=> (r_phase == b64ce_pkg::PH_FIRST) && (r_carry == '0))
        else $error("group state not cleared after message end");

    a_phase_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == b64ce_pkg::PH_SECOND) |-> (r_carry[3:2] == 2'b00))
        else $error("carry holds stray bits after first byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_cnt) && $stable(o_out_char))
        else $error("buffer changed while output stalled");

endmodule
